>>> hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque core.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DataW   = 32;
    localparam int CmdW    = 3;
    localparam int StatW   = 2;
    localparam int CountW  = 5;

    localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CmdW-1:0] CMD_PEEK       = 3'd4;

    localparam logic [StatW-1:0] STAT_OK    = 2'd0;
    localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
    localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    // Sequencer strobes toward the datapath.
    typedef struct packed {
        logic exec;
        logic done;
    } t_ctrl;

endpackage

>>> hw/rtl/cdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cdq_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_fsm
// Command sequencer: accept, execute with one memory access, report.
// ----------------------------------------------------------------------------
module cdq_fsm
    import cdq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy      = 1'b1;
        o_ctrl.exec = 1'b0;
        o_ctrl.done = 1'b0;
        unique case (r_state)
            ST_IDLE: o_busy = 1'b0;
            ST_EXEC: o_ctrl.exec = 1'b1;
            ST_DONE: o_ctrl.done = 1'b1;
            default: o_busy = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/circular_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_core
// Fixed-capacity double-ended queue held in a circular RAM.
//
//   Channel   Signals                          Transfer
//   command   start, busy, i_cmd, i_value      beat when start && !busy
//   result    o_done, o_popped_value .. etc    one-cycle beat on o_done
//
// Each command passes through accept, execute (one RAM write for a push
// or one RAM read for a pop), then the result beat; busy stays high from
// the execute step through the result-beat cycle.
// The front and back entries are cached
// in registers so a pop needs only one RAM read to refill its end.
// Reset clears the front pointer and count and sets the back pointer to the last slot; RAM contents are not cleared.
// The receiver cannot stall the result beat.
// ----------------------------------------------------------------------------
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CmdW-1:0]          i_cmd,
    input  logic signed [DataW-1:0]  i_value,
    output logic                     o_done,
    output logic signed [DataW-1:0]  o_popped_value,
    output logic [StatW-1:0]         o_status,
    output logic [CountW-1:0]        o_count,
    output logic signed [DataW-1:0]  o_front_value,
    output logic signed [DataW-1:0]  o_back_value,
    output logic                     o_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    t_ctrl w_ctrl;

    logic [CmdW-1:0]  r_cmd;
    logic [DataW-1:0] r_value;
    logic [AW-1:0]    r_front, n_front;
    logic [AW-1:0]    r_back, n_back;
    logic [CW-1:0]    r_count, n_count;
    logic [DataW-1:0] r_front_val, n_front_val;
    logic [DataW-1:0] r_back_val, n_back_val;
    logic [DataW-1:0] r_popped, n_popped;
    logic [StatW-1:0] r_status, n_status;
    logic             r_refill_front, n_refill_front;
    logic             r_refill_back, n_refill_back;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [DataW-1:0] w_rdata;
    logic             w_full;
    logic             w_empty;
    logic [AW-1:0]    w_front_inc, w_front_dec, w_back_inc, w_back_dec;
    logic [DataW-1:0] w_front_now, w_back_now;
    logic [CW+CountW-1:0] w_count_ext;

    cdq_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (w_ctrl)
    );

    cdq_ram #(
        .WIDTH (DataW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
    end

    assign w_full  = (r_count == FullCnt);
    assign w_empty = (r_count == '0);

    assign w_front_inc = (r_front == LastIdx) ? '0 : r_front + 1'b1;
    assign w_front_dec = (r_front == '0) ? LastIdx : r_front - 1'b1;
    assign w_back_inc  = (r_back == LastIdx) ? '0 : r_back + 1'b1;
    assign w_back_dec  = (r_back == '0) ? LastIdx : r_back - 1'b1;

    always_comb begin
        n_front        = r_front;
        n_back         = r_back;
        n_count        = r_count;
        n_front_val    = r_front_val;
        n_back_val     = r_back_val;
        n_popped       = '0;
        n_status       = STAT_OK;
        n_refill_front = 1'b0;
        n_refill_back  = 1'b0;
        w_we           = 1'b0;
        w_waddr        = w_front_dec;
        w_raddr        = w_front_inc;
        unique case (r_cmd)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_front     = w_front_dec;
                    n_count     = r_count + 1'b1;
                    n_front_val = r_value;
                    w_we        = w_ctrl.exec;
                    w_waddr     = w_front_dec;
                    if (w_empty) begin
                        n_back_val = r_value;
                    end
                end
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_back     = w_back_inc;
                    n_count    = r_count + 1'b1;
                    n_back_val = r_value;
                    w_we       = w_ctrl.exec;
                    w_waddr    = w_back_inc;
                    if (w_empty) begin
                        n_front_val = r_value;
                    end
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_popped       = r_front_val;
                    n_front        = w_front_inc;
                    n_count        = r_count - 1'b1;
                    w_raddr        = w_front_inc;
                    // Only refill when an entry remains behind the popped one.
                    n_refill_front = (r_count != CW'(1));
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_popped      = r_back_val;
                    n_back        = w_back_dec;
                    n_count       = r_count - 1'b1;
                    w_raddr       = w_back_dec;
                    n_refill_back = (r_count != CW'(1));
                end
            end
            CMD_PEEK: begin
                n_status = STAT_OK;
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front        <= '0;
            r_back         <= LastIdx;
            r_count        <= '0;
            r_refill_front <= 1'b0;
            r_refill_back  <= 1'b0;
        end else if (w_ctrl.exec) begin
            r_front        <= n_front;
            r_back         <= n_back;
            r_count        <= n_count;
            r_refill_front <= n_refill_front;
            r_refill_back  <= n_refill_back;
        end else if (w_ctrl.done) begin
            r_refill_front <= 1'b0;
            r_refill_back  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.exec) begin
            r_front_val <= n_front_val;
            r_back_val  <= n_back_val;
            r_popped    <= n_popped;
            r_status    <= n_status;
        end else if (w_ctrl.done) begin
            r_front_val <= w_front_now;
            r_back_val  <= w_back_now;
        end
    end

    assign w_front_now = r_refill_front ? w_rdata : r_front_val;
    assign w_back_now  = r_refill_back ? w_rdata : r_back_val;
    assign w_count_ext = (CW + CountW)'(r_count);

    assign o_done         = w_ctrl.done;
    assign o_popped_value = w_ctrl.done ? r_popped : '0;
    assign o_status       = w_ctrl.done ? r_status : STAT_OK;
    assign o_count        = w_ctrl.done ? w_count_ext[CountW-1:0] : '0;
    assign o_is_empty     = w_ctrl.done && w_empty;
    assign o_front_value  = (w_ctrl.done && !w_empty) ? w_front_now : '0;
    assign o_back_value   = (w_ctrl.done && !w_empty) ? w_back_now : '0;

endmodule

>>> hw/rtl/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque core, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_done,
    input logic [StatW-1:0]        o_status,
    input logic [CountW-1:0]       o_count,
    input logic signed [DataW-1:0] o_front_value,
    input logic signed [DataW-1:0] o_back_value,
    input logic                    o_is_empty
);

    // An accepted command holds the core busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a command");

    // A result beat is never followed directly by another.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat repeated");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_empty) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("nonzero end values on an empty deque");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STAT_FULL) |-> (o_count == CountW'(DEPTH)))
        else $error("full status below capacity");

endmodule

bind circular_deque_core cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_count       (o_count),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_is_empty    (o_is_empty)
);

>>> verif/circular_deque_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_core_tb
// Self-checking bench for the circular deque core. A driver presents commands
// from a pending queue with random gaps. A monitor predicts the deque state
// for every accepted command and checks each result beat against the oldest
// prediction. Directed commands cover the empty, full, extreme-value and
// unused-command cases. Random bursts then fill, drain and mix the deque.
// ----------------------------------------------------------------------------
module circular_deque_core_tb;
    import cdq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int RANDOM_ITEMS   = 925;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        logic [CmdW-1:0]         cmd;
        logic signed [DataW-1:0] value;
        int                      gap;
    } t_deque_cmd;

    typedef struct {
        logic signed [DataW-1:0] popped;
        logic [StatW-1:0]        status;
        logic [CountW-1:0]       count;
        logic signed [DataW-1:0] front;
        logic signed [DataW-1:0] back;
        logic                    empty;
    } t_deque_view;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CmdW-1:0]         i_cmd;
    logic signed [DataW-1:0] i_value;
    logic                    o_done;
    logic signed [DataW-1:0] o_popped_value;
    logic [StatW-1:0]        o_status;
    logic [CountW-1:0]       o_count;
    logic signed [DataW-1:0] o_front_value;
    logic signed [DataW-1:0] o_back_value;
    logic                    o_is_empty;

    t_deque_cmd  cmd_queue[$];
    t_deque_view predicted_views[$];
    int          n_items;
    int          n_accepted = 0;
    int          errors     = 0;
    int          wait_cnt   = 0;
    logic        beat_taken = 1'b0;

    // Shadow copy of the deque.
    logic signed [DataW-1:0] shadow_slots [DEPTH];
    int                      shadow_front;
    int                      shadow_back;
    int                      shadow_count;

    circular_deque_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_is_empty     (o_is_empty)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_deque_view apply_deque_cmd(logic [CmdW-1:0] cmd,
                                                    logic signed [DataW-1:0] value);
        t_deque_view v;
        v.popped = '0;
        v.status = STAT_OK;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
            if (shadow_count >= DEPTH) begin
                v.status = STAT_FULL;
            end else if (cmd == CMD_PUSH_FRONT) begin
                shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                shadow_slots[shadow_front] = value;
                shadow_count++;
            end else begin
                shadow_back = (shadow_back + 1) % DEPTH;
                shadow_slots[shadow_back] = value;
                shadow_count++;
            end
        end else if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
            if (shadow_count == 0) begin
                v.status = STAT_EMPTY;
            end else if (cmd == CMD_POP_FRONT) begin
                v.popped = shadow_slots[shadow_front];
                shadow_front = (shadow_front + 1) % DEPTH;
                shadow_count--;
            end else begin
                v.popped = shadow_slots[shadow_back];
                shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
                shadow_count--;
            end
        end
        v.count = shadow_count[CountW-1:0];
        v.empty = (shadow_count == 0);
        v.front = v.empty ? '0 : shadow_slots[shadow_front];
        v.back  = v.empty ? '0 : shadow_slots[shadow_back];
        return v;
    endfunction

    task automatic check_field(string name, logic [DataW-1:0] exp_v, logic [DataW-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic add_cmd(logic [CmdW-1:0] cmd, logic signed [DataW-1:0] value, int gap);
        t_deque_cmd c;
        c.cmd   = cmd;
        c.value = value;
        c.gap   = gap;
        cmd_queue.push_back(c);
    endtask

    function automatic logic signed [DataW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Driver: holds a command until its beat is taken, then waits out the gap
    // drawn for the next one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !beat_taken) begin
            start <= 1'b1;
        end else if (cmd_queue.size() == 0) begin
            start <= 1'b0;
        end else if (wait_cnt < cmd_queue[0].gap) begin
            start <= 1'b0;
            wait_cnt++;
        end else begin
            start   <= 1'b1;
            i_cmd   <= cmd_queue[0].cmd;
            i_value <= cmd_queue[0].value;
            void'(cmd_queue.pop_front());
            wait_cnt = 0;
        end
    end

    // Monitor: the result beat is checked before a command accepted at the
    // same edge adds its prediction.
    always @(posedge i_clk) begin : monitor
        t_deque_view exp_v;
        if (i_rst_n && o_done === 1'b1) begin
            if (predicted_views.size() == 0) begin
                $error("result beat with no prediction waiting");
                errors++;
            end else begin
                exp_v = predicted_views.pop_front();
                check_field("popped_value", exp_v.popped, o_popped_value);
                check_field("status", DataW'(exp_v.status), DataW'(o_status));
                check_field("count", DataW'(exp_v.count), DataW'(o_count));
                check_field("front_value", exp_v.front, o_front_value);
                check_field("back_value", exp_v.back, o_back_value);
                check_field("is_empty", DataW'(exp_v.empty), DataW'(o_is_empty));
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            predicted_views.push_back(apply_deque_cmd(i_cmd, i_value));
            n_accepted++;
        end
        beat_taken <= i_rst_n && start && (busy === 1'b0);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (o_done === 1'b1 || (start && busy === 1'b0)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int burst_len;
        int r;
        int gap_on;
        logic [CmdW-1:0] c;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = CMD_PEEK;
        i_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_slots[i] = '0;
        end
        shadow_front = 0;
        shadow_back  = DEPTH - 1;
        shadow_count = 0;

        // Empty deque: peek, then refused pops on both ends.
        add_cmd(CMD_PEEK, 32'sh1234_5678, 0);
        add_cmd(CMD_POP_FRONT, '0, 0);
        add_cmd(CMD_POP_BACK, -32'sd1, 2);
        add_cmd(CMD_PUSH_FRONT, 32'sh8000_0000, 0);
        // Unused command codes behave as a peek.
        add_cmd(CmdW'(5), 32'sh5555_5555, 1);
        add_cmd(CmdW'(7), -32'sd1, 0);
        add_cmd(CMD_PUSH_BACK, 32'sh7FFF_FFFF, 0);
        add_cmd(CMD_POP_BACK, '0, 3);
        add_cmd(CMD_POP_FRONT, '0, 0);
        // Fill from both ends, then push into a full deque.
        for (int i = 0; i < DEPTH; i++) begin
            add_cmd((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                    (i % 3 == 0) ? -32'(i) : 32'sh00A5_0000 + i, (i % 4 == 3) ? 1 : 0);
        end
        add_cmd(CMD_PUSH_BACK, 32'sh0F0F_0F0F, 0);
        add_cmd(CMD_PUSH_FRONT, 32'shF0F0_F0F0, 0);

        // Random bursts that fill, drain or mix, with idling on or off.
        r = 0;
        while (r < RANDOM_ITEMS) begin
            kind      = $urandom_range(0, 2);
            burst_len = $urandom_range(4, 30);
            gap_on    = $urandom_range(0, 1);
            for (int i = 0; i < burst_len && r < RANDOM_ITEMS; i++) begin
                case (kind)
                    0: begin
                        case ($urandom_range(0, 9))
                            8:       c = CmdW'($urandom_range(2, 3));
                            9:       c = CmdW'($urandom_range(4, 7));
                            default: c = CmdW'($urandom_range(0, 1));
                        endcase
                    end
                    1: begin
                        case ($urandom_range(0, 9))
                            8:       c = CmdW'($urandom_range(0, 1));
                            9:       c = CmdW'($urandom_range(4, 7));
                            default: c = CmdW'($urandom_range(2, 3));
                        endcase
                    end
                    default: c = CmdW'($urandom_range(0, 7));
                endcase
                add_cmd(c, pick_value(), gap_on ? $urandom_range(0, 5) : 0);
                r++;
            end
        end
        n_items = cmd_queue.size();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items || predicted_views.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (predicted_views.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_views.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
